@@ rtl/core/tlss_pkg.sv @@
package tlss_pkg;

   // Fixed protocol constants.
   localparam int unsigned BLOCK_BYTES = 512;
   localparam logic [10:0] HDR_BYTES   = 11'd21;
   localparam logic [10:0] ETH_HDR     = 11'd14;
   localparam logic [7:0]  OWN_SAP     = 8'd68;
   localparam logic [7:0]  UI_CONTROL  = 8'h03;

   // TFTP opcodes.
   localparam logic [15:0] OP_RRQ  = 16'd1;
   localparam logic [15:0] OP_WRQ  = 16'd2;
   localparam logic [15:0] OP_DATA = 16'd3;
   localparam logic [15:0] OP_ACK  = 16'd4;
   localparam logic [15:0] OP_ERR  = 16'd5;

   // LLC length of a full and of an empty DATA frame.
   localparam logic [15:0] DATA_LLC_FULL  = 16'(7 + BLOCK_BYTES);
   localparam logic [15:0] DATA_LLC_EMPTY = 16'd7;

   // Status codes.
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_DROPPED    = 4'd1;
   localparam logic [3:0] ST_NO_SESSION = 4'd2;
   localparam logic [3:0] ST_WRONG_MODE = 4'd3;
   localparam logic [3:0] ST_BAD_SIZE   = 4'd4;
   localparam logic [3:0] ST_OUT_OF_SEQ = 4'd5;
   localparam logic [3:0] ST_ERR_RX     = 4'd6;
   localparam logic [3:0] ST_UNKNOWN_OP = 4'd7;

   // Configuration register indexes.
   localparam logic REG_OWN_MAC      = 1'b0;
   localparam logic REG_IMAGE_BLOCKS = 1'b1;

   // Request class found by the front end.
   typedef enum logic [2:0] {
      KIND_SHORT,
      KIND_RRQ,
      KIND_WRQ,
      KIND_DATA,
      KIND_ACK,
      KIND_ERR,
      KIND_OTHER
   } kind_type;

   // Classified request passed from front end to back end.
   typedef struct packed {
      kind_type    kind;
      logic        size_ok;
      logic [15:0] rx_block;
      logic [47:0] peer_mac;
      logic [7:0]  peer_sap;
   } cls_type;

   // Reply descriptor.
   typedef struct packed {
      logic        reply_valid;
      logic [47:0] reply_dest_mac;
      logic [15:0] reply_llc_len;
      logic [7:0]  reply_dsap;
      logic [7:0]  reply_ssap;
      logic [7:0]  reply_control;
      logic [15:0] reply_opcode;
      logic [15:0] reply_block;
      logic [10:0] reply_total_len;
      logic        flash_read;
      logic [15:0] flash_block;
      logic [3:0]  status;
   } rsp_type;

endpackage

@@ rtl/core/tlss_fifo.sv @@
module tlss_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

@@ rtl/core/tlss_front.sv @@
module tlss_front (
   input  logic [10:0]      frame_len,
   input  logic [15:0]      llc_len,
   input  logic [15:0]      tftp_opcode,
   input  logic [15:0]      rx_block,
   input  logic [47:0]      peer_mac,
   input  logic [7:0]       peer_sap,
   output tlss_pkg::cls_type cls
);
   import tlss_pkg::*;

   logic [16:0] need_len;
   logic        short_frame;

   // A frame is short if it cannot hold the headers or the LLC payload it claims.
   assign need_len    = {1'b0, llc_len} + 17'(ETH_HDR);
   assign short_frame = (frame_len < HDR_BYTES) || ({6'd0, frame_len} < need_len);

   // Classify the request by opcode; a short frame is classed as short instead.
   always_comb begin
      cls.size_ok  = (llc_len == DATA_LLC_FULL) || (llc_len == DATA_LLC_EMPTY);
      cls.rx_block = rx_block;
      cls.peer_mac = peer_mac;
      cls.peer_sap = peer_sap;
      if (short_frame) begin
         cls.kind = KIND_SHORT;
      end else begin
         unique case (tftp_opcode)
            OP_RRQ:  cls.kind = KIND_RRQ;
            OP_WRQ:  cls.kind = KIND_WRQ;
            OP_DATA: cls.kind = KIND_DATA;
            OP_ACK:  cls.kind = KIND_ACK;
            OP_ERR:  cls.kind = KIND_ERR;
            default: cls.kind = KIND_OTHER;
         endcase
      end
   end

endmodule

@@ rtl/core/tlss_back.sv @@
module tlss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       image_blocks,
   input  logic              fire,
   input  tlss_pkg::cls_type cls,
   output tlss_pkg::rsp_type rsp
);
   import tlss_pkg::*;

   logic        open_ff, open_in;
   logic        sending_ff, sending_in;
   logic        receiving_ff, receiving_in;
   logic [15:0] counter_ff, counter_in;
   logic [15:0] send_base;
   logic [15:0] send_blk;
   logic        avail;

   // DATA reply numbering: RRQ starts from zero, an ACK from the counter.
   assign send_base = (cls.kind == KIND_RRQ) ? 16'd0 : counter_ff;
   assign send_blk  = send_base + 16'd1;
   assign avail     = send_base < image_blocks;

   // Session update and reply build.
   always_comb begin
      open_in      = open_ff;
      sending_in   = sending_ff;
      receiving_in = receiving_ff;
      counter_in   = counter_ff;
      rsp          = '0;
      unique case (cls.kind)
         KIND_SHORT: rsp.status = ST_DROPPED;
         KIND_RRQ, KIND_WRQ: begin
            open_in      = 1'b1;
            sending_in   = (cls.kind == KIND_RRQ);
            receiving_in = (cls.kind == KIND_WRQ);
            counter_in   = (cls.kind == KIND_RRQ) ? send_blk : 16'd0;
            rsp.reply_valid  = 1'b1;
            rsp.reply_opcode = (cls.kind == KIND_RRQ) ? OP_DATA : OP_ACK;
            rsp.reply_block  = counter_in;
         end
         KIND_DATA: begin
            if (!open_ff) begin
               rsp.status = ST_NO_SESSION;
            end else if (!receiving_ff) begin
               rsp.status = ST_WRONG_MODE;
            end else if (!cls.size_ok) begin
               rsp.status = ST_BAD_SIZE;
            end else if (cls.rx_block != send_blk) begin
               rsp.status = ST_OUT_OF_SEQ;
            end else begin
               counter_in       = send_blk;
               rsp.reply_valid  = 1'b1;
               rsp.reply_opcode = OP_ACK;
               rsp.reply_block  = send_blk;
            end
         end
         KIND_ACK: begin
            if (!open_ff) begin
               rsp.status = ST_NO_SESSION;
            end else if (!sending_ff) begin
               rsp.status = ST_WRONG_MODE;
            end else if (cls.rx_block != counter_ff) begin
               rsp.status = ST_OUT_OF_SEQ;
            end else begin
               counter_in       = send_blk;
               rsp.reply_valid  = 1'b1;
               rsp.reply_opcode = OP_DATA;
               rsp.reply_block  = send_blk;
            end
         end
         KIND_ERR: rsp.status = ST_ERR_RX;
         default:  rsp.status = ST_UNKNOWN_OP;
      endcase

      // Common reply fields; a DATA reply carries a flash block when available.
      if (rsp.reply_valid) begin
         rsp.reply_dest_mac  = cls.peer_mac;
         rsp.reply_dsap      = cls.peer_sap;
         rsp.reply_ssap      = OWN_SAP;
         rsp.reply_control   = UI_CONTROL;
         rsp.reply_total_len = HDR_BYTES;
         if (rsp.reply_opcode == OP_DATA && avail) begin
            rsp.reply_total_len = HDR_BYTES + 11'(BLOCK_BYTES);
            rsp.flash_read      = 1'b1;
            rsp.flash_block     = send_base;
         end
         rsp.reply_llc_len = {5'd0, rsp.reply_total_len - ETH_HDR};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         sending_ff   <= 1'b0;
         receiving_ff <= 1'b0;
         counter_ff   <= '0;
      end else if (fire) begin
         open_ff      <= open_in;
         sending_ff   <= sending_in;
         receiving_ff <= receiving_in;
         counter_ff   <= counter_in;
      end
   end

endmodule

@@ rtl/core/tftp_llc_server_step_top.sv @@
// TFTP-over-LLC server step. Each request is the header summary of one received
// frame and yields exactly one reply descriptor, in order. The block takes one
// request per clock cycle while req_full is low. The front end classifies
// requests into a short queue, and the back end applies them to the session
// state (open flag, mode, block counter), one per cycle while the reply queue
// is not full, into the reply queue. Write own_mac at byte address 0 and
// image_blocks at byte address 8, only while no request is in flight.
module tftp_llc_server_step_top #(
   parameter int QUEUE_DEPTH = 2,
   parameter int REPLY_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_push,
   output logic        req_full,
   input  logic [10:0] req_frame_len,
   input  logic [15:0] req_llc_len,
   input  logic [15:0] req_tftp_opcode,
   input  logic [15:0] req_rx_block,
   input  logic [47:0] req_peer_mac,
   input  logic [7:0]  req_peer_sap,
   // Reply channel.
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_reply_valid,
   output logic [47:0] rsp_reply_dest_mac,
   output logic [15:0] rsp_reply_llc_len,
   output logic [7:0]  rsp_reply_dsap,
   output logic [7:0]  rsp_reply_ssap,
   output logic [7:0]  rsp_reply_control,
   output logic [15:0] rsp_reply_opcode,
   output logic [15:0] rsp_reply_block,
   output logic [10:0] rsp_reply_total_len,
   output logic        rsp_flash_read,
   output logic [15:0] rsp_flash_block,
   output logic [3:0]  rsp_status,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import tlss_pkg::*;

   localparam int CLS_W = $bits(cls_type);
   localparam int RSP_W = $bits(rsp_type);

   logic [47:0]      own_mac_ff;
   logic [15:0]      image_blocks_ff;
   logic             csr_write;
   cls_type          cls_new;
   cls_type          cls_head;
   logic [CLS_W-1:0] cls_head_bits;
   logic             mid_empty;
   logic             out_full;
   logic             fire;
   rsp_type          rsp_new;
   rsp_type          rsp_head;
   logic [RSP_W-1:0] rsp_head_bits;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == REG_IMAGE_BLOCKS) ? {48'd0, image_blocks_ff}
                                                          : {16'd0, own_mac_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff      <= '0;
         image_blocks_ff <= '0;
      end else if (csr_write) begin
         if (csr_paddr[3] == REG_OWN_MAC) begin
            own_mac_ff <= csr_pwdata[47:0];
         end else begin
            image_blocks_ff <= csr_pwdata[15:0];
         end
      end
   end

   // Front end: classify each request.
   tlss_front u_front (
      .frame_len   (req_frame_len),
      .llc_len     (req_llc_len),
      .tftp_opcode (req_tftp_opcode),
      .rx_block    (req_rx_block),
      .peer_mac    (req_peer_mac),
      .peer_sap    (req_peer_sap),
      .cls         (cls_new)
   );

   // Queue between front end and back end.
   tlss_fifo #(
      .WIDTH (CLS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (cls_new),
      .full  (req_full),
      .pop   (fire),
      .dout  (cls_head_bits),
      .empty (mid_empty)
   );

   assign cls_head = cls_type'(cls_head_bits);
   assign fire     = !mid_empty && !out_full;

   // Back end: session state and reply build.
   tlss_back u_back (
      .clock        (clock),
      .reset        (reset),
      .image_blocks (image_blocks_ff),
      .fire         (fire),
      .cls          (cls_head),
      .rsp          (rsp_new)
   );

   // Reply queue.
   tlss_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (REPLY_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (fire),
      .din   (rsp_new),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (rsp_head_bits),
      .empty (rsp_empty)
   );

   assign rsp_head            = rsp_type'(rsp_head_bits);
   assign rsp_reply_valid     = rsp_head.reply_valid;
   assign rsp_reply_dest_mac  = rsp_head.reply_dest_mac;
   assign rsp_reply_llc_len   = rsp_head.reply_llc_len;
   assign rsp_reply_dsap      = rsp_head.reply_dsap;
   assign rsp_reply_ssap      = rsp_head.reply_ssap;
   assign rsp_reply_control   = rsp_head.reply_control;
   assign rsp_reply_opcode    = rsp_head.reply_opcode;
   assign rsp_reply_block     = rsp_head.reply_block;
   assign rsp_reply_total_len = rsp_head.reply_total_len;
   assign rsp_flash_read      = rsp_head.flash_read;
   assign rsp_flash_block     = rsp_head.flash_block;
   assign rsp_status          = rsp_head.status;

endmodule
